/* src/idmr_pkg.sv */
// Shared types and constants for the int8 dense MAC with requantization.
// Used by the controller, the datapath and the top level; no dependencies.
package idmr_pkg;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_ACC = 5'b00001,
    ST_MUL = 5'b00010,
    ST_SHF = 5'b00100,
    ST_RND = 5'b01000,
    ST_OUT = 5'b10000
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic acc_en;
    logic mul_en;
    logic shf_en;
    logic rnd_en;
    logic out_load;
  } cmd_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_QMULT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QSHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INOFF  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTZP  = 2'd3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration reset values
  localparam logic [30:0] QMULT_RST  = 31'h4000_0000;
  localparam logic [5:0]  QSHIFT_RST = 6'd0;
  localparam logic [8:0]  INOFF_RST  = 9'd128;
  localparam logic [7:0]  OUTZP_RST  = 8'h80;

  // Rounding nudges for the doubling high multiply, modulo 2^63
  localparam logic [62:0] NUDGE_POS = 63'h0000_0000_4000_0000;
  localparam logic [62:0] NUDGE_NEG = 63'h7FFF_FFFF_C000_0001;

  // int8 saturation limits
  localparam logic signed [7:0] RES_MIN = -8'sd128;
  localparam logic signed [7:0] RES_MAX = 8'sd127;

endpackage

/* src/idmr_ctrl.sv */
// Controller state machine for the int8 dense MAC with requantization.
// Depends on idmr_pkg for the state and command types.
module idmr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_stall,
  input  logic            out_stall,
  output logic            out_valid,
  output idmr_pkg::cmd_t  cmd
);

  idmr_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_xfer;
  logic             out_free;

  assign in_stall = (state_r != idmr_pkg::ST_ACC);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Issue datapath commands
  always_comb begin
    cmd          = '0;
    cmd.acc_en   = in_xfer;
    cmd.mul_en   = (state_r == idmr_pkg::ST_MUL);
    cmd.shf_en   = (state_r == idmr_pkg::ST_SHF);
    cmd.rnd_en   = (state_r == idmr_pkg::ST_RND);
    cmd.out_load = (state_r == idmr_pkg::ST_OUT) && out_free;
  end

  // Advance through the requantize sequence after a last item
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      idmr_pkg::ST_ACC: begin
        if (in_xfer && in_last) state_nxt = idmr_pkg::ST_MUL;
      end
      idmr_pkg::ST_MUL: state_nxt = idmr_pkg::ST_SHF;
      idmr_pkg::ST_SHF: state_nxt = idmr_pkg::ST_RND;
      idmr_pkg::ST_RND: state_nxt = idmr_pkg::ST_OUT;
      idmr_pkg::ST_OUT: begin
        if (out_free) state_nxt = idmr_pkg::ST_ACC;
      end
      default: state_nxt = idmr_pkg::ST_ACC;
    endcase
  end

  // Hold the result valid until its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= idmr_pkg::ST_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* src/idmr_datapath.sv */
// Datapath for the int8 dense MAC: config registers, accumulator and the
// staged requantize pipeline. Depends on idmr_pkg for commands and constants.
module idmr_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  idmr_pkg::cmd_t                      cmd,
  input  logic                                cfg_we,
  input  logic [idmr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [idmr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_first,
  input  logic signed [7:0]                   in_activation,
  input  logic signed [7:0]                   in_weight,
  input  logic signed [31:0]                  in_bias,
  output logic signed [7:0]                   out_result
);

  // Configuration registers
  logic [30:0]        qmult_r;
  logic [5:0]         qshift_r;
  logic signed [8:0]  inoff_r;
  logic signed [7:0]  outzp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qmult_r  <= idmr_pkg::QMULT_RST;
      qshift_r <= idmr_pkg::QSHIFT_RST;
      inoff_r  <= idmr_pkg::INOFF_RST;
      outzp_r  <= idmr_pkg::OUTZP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        idmr_pkg::CFG_QMULT:  qmult_r  <= cfg_data[30:0];
        idmr_pkg::CFG_QSHIFT: qshift_r <= cfg_data[5:0];
        idmr_pkg::CFG_INOFF:  inoff_r  <= cfg_data[8:0];
        idmr_pkg::CFG_OUTZP:  outzp_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Split the shift into left and right amounts
  logic [4:0] left_amt;
  logic [5:0] right_amt;
  logic       shift_pos;

  assign shift_pos = !qshift_r[5] && (qshift_r != 6'd0);
  assign left_amt  = shift_pos ? qshift_r[4:0] : 5'd0;
  assign right_amt = shift_pos ? 6'd0 : 6'(-qshift_r);

  // Multiply-accumulate, wrapping at 32 bits
  logic signed [9:0]  act_off;
  logic signed [17:0] mac_prod;
  logic [31:0]        acc_base;
  logic [31:0]        acc_r, acc_nxt;

  assign act_off  = $signed({{2{in_activation[7]}}, in_activation})
                  + $signed({inoff_r[8], inoff_r});
  assign mac_prod = act_off * in_weight;
  assign acc_base = in_first ? in_bias : acc_r;
  assign acc_nxt  = acc_base + {{14{mac_prod[17]}}, mac_prod};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  // Stage 1: accumulator times multiplier, low 63 bits kept
  logic signed [63:0] mul_full;
  logic [62:0]        mul_r;
  logic               neg_r;

  assign mul_full = $signed(acc_r) * $signed({1'b0, qmult_r});

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      mul_r <= mul_full[62:0];
      neg_r <= acc_r[31] && (qmult_r != 31'd0);
    end
  end

  // Stage 2: apply left shift, add nudge, take the high word
  logic [62:0] shl;
  logic [62:0] nudged;
  logic [31:0] high_r;

  assign shl    = mul_r << left_amt;
  assign nudged = shl + (neg_r ? idmr_pkg::NUDGE_NEG : idmr_pkg::NUDGE_POS);

  always_ff @(posedge clk) begin
    if (cmd.shf_en) begin
      high_r <= nudged[62:31];
    end
  end

  // Stage 3: rounding right shift
  logic signed [32:0] hx;
  logic signed [32:0] floor_v;
  logic [32:0]        mask;
  logic [32:0]        rem;
  logic [32:0]        thresh;
  logic               rnd_bit;
  logic signed [32:0] rnd_r;

  assign hx      = $signed({high_r[31], high_r});
  assign floor_v = hx >>> right_amt;
  assign mask    = (33'd1 << right_amt) - 33'd1;
  assign rem     = {1'b0, high_r} & mask;
  assign thresh  = (mask >> 1) + {32'd0, high_r[31]};
  assign rnd_bit = rem > thresh;

  always_ff @(posedge clk) begin
    if (cmd.rnd_en) begin
      rnd_r <= floor_v + $signed({32'd0, rnd_bit});
    end
  end

  // Stage 4: add zero point, saturate, load output register
  logic signed [33:0] zp_sum;
  logic signed [7:0]  sat_v;
  logic signed [7:0]  res_r;

  assign zp_sum = $signed({rnd_r[32], rnd_r}) + $signed({{26{outzp_r[7]}}, outzp_r});

  always_comb begin
    if (zp_sum < 34'(idmr_pkg::RES_MIN)) begin
      sat_v = idmr_pkg::RES_MIN;
    end else if (zp_sum > 34'(idmr_pkg::RES_MAX)) begin
      sat_v = idmr_pkg::RES_MAX;
    end else begin
      sat_v = zp_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_r <= sat_v;
    end
  end

  assign out_result = res_r;

endmodule

/* src/int8_dense_mac_requantize.sv */
// int8 dense MAC with requantization: one item accepted per cycle while
// accumulating; a last item starts a four-stage requantize sequence
// (multiply, shift and nudge, round, saturate), and input stalls until its
// result is loaded into the output register, longer while the previous
// result is held by out_stall. Synchronous active-low reset clears the
// accumulator and control state and restores config defaults.
module int8_dense_mac_requantize (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_first,
  input  logic                                in_last,
  input  logic signed [7:0]                   in_activation,
  input  logic signed [7:0]                   in_weight,
  input  logic signed [31:0]                  in_bias,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [7:0]                   out_result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [idmr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [idmr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  idmr_pkg::cmd_t cmd;
  logic           cfg_we;

  // Take config writes at any time
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  idmr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  idmr_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_first      (in_first),
    .in_activation (in_activation),
    .in_weight     (in_weight),
    .in_bias       (in_bias),
    .out_result    (out_result)
  );

  // A last item reaches the rounding stage after the multiply and shift stages
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> ##2 cmd.rnd_en)
    else $error("requantize sequence did not reach rounding stage");

  // Loading the output register raises valid
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("output load did not present a result");

  // A new result appears only through an output load
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result valid rose without an output load");

endmodule

/* bench/int8_dense_mac_requantize_test.sv */
// Self-checking testbench for the int8 dense MAC with requantization.
// Depends on idmr_pkg and int8_dense_mac_requantize; predicts every neuron
// output from a local copy of the accumulator and register settings.
module int8_dense_mac_requantize_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic               first;
    logic               last;
    logic signed [7:0]  activation;
    logic signed [7:0]  weight;
    logic signed [31:0] bias;
  } mac_item_t;

  logic                            clk           = 1'b0;
  logic                            rst_n         = 1'b0;
  logic                            in_valid      = 1'b0;
  logic                            in_stall;
  logic                            in_first      = 1'b0;
  logic                            in_last       = 1'b0;
  logic signed [7:0]               in_activation = '0;
  logic signed [7:0]               in_weight     = '0;
  logic signed [31:0]              in_bias       = '0;
  logic                            out_valid;
  logic                            out_stall     = 1'b0;
  logic signed [7:0]               out_result;
  logic                            cfg_valid     = 1'b0;
  logic                            cfg_ready;
  logic [idmr_pkg::CFG_IDX_W-1:0]  cfg_index     = idmr_pkg::CFG_QMULT;
  logic [idmr_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

  // Local copy of the block's state and registers
  logic [31:0]        mac_sum       = 32'd0;
  logic [30:0]        shadow_qmult  = idmr_pkg::QMULT_RST;
  logic signed [5:0]  shadow_qshift = idmr_pkg::QSHIFT_RST;
  logic signed [8:0]  shadow_inoff  = idmr_pkg::INOFF_RST;
  logic signed [7:0]  shadow_zp     = idmr_pkg::OUTZP_RST;

  mac_item_t         queued_items[$];
  logic signed [7:0] predicted_results[$];
  int                mismatch_count = 0;
  int                send_gap = 0;
  int                recv_gap = 0;
  int                hold_left = 0;
  bit                send_calm = 1'b0;
  bit                recv_calm = 1'b0;
  bit                hold_phase = 1'b0;
  bit                hold_done = 1'b0;

  int8_dense_mac_requantize u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_first      (in_first),
    .in_last       (in_last),
    .in_activation (in_activation),
    .in_weight     (in_weight),
    .in_bias       (in_bias),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result    (out_result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Scale the 32-bit sum to int8: left shift, rounding doubling high
  // multiply, rounding right shift, zero point, saturation
  function automatic logic signed [7:0] requantize_sum(input logic [31:0] sum);
    int                 s;
    int                 lsh;
    int                 rsh;
    logic [63:0]        scaled;
    logic [63:0]        prod;
    logic [63:0]        rounded;
    logic [63:0]        mask;
    logic [63:0]        rem;
    logic [63:0]        thresh;
    logic signed [63:0] hi;
    logic signed [63:0] total;
    s = shadow_qshift;
    lsh = (s > 0) ? s : 0;
    rsh = (s > 0) ? 0 : -s;
    scaled = {{32{sum[31]}}, sum} << lsh;
    prod = scaled * {33'd0, shadow_qmult};
    if (sum[31] && shadow_qmult != 31'd0) rounded = prod + 64'hFFFF_FFFF_C000_0001;
    else rounded = prod + 64'h0000_0000_4000_0000;
    hi = {{32{rounded[62]}}, rounded[62:31]};
    if (rsh > 0) begin
      mask = (64'd1 << rsh) - 64'd1;
      rem = hi & mask;
      thresh = (mask >> 1) + ((hi < 0) ? 64'd1 : 64'd0);
      hi = (hi >>> rsh) + ((rem > thresh) ? 64'sd1 : 64'sd0);
    end
    total = hi + shadow_zp;
    if (total < idmr_pkg::RES_MIN) return idmr_pkg::RES_MIN;
    if (total > idmr_pkg::RES_MAX) return idmr_pkg::RES_MAX;
    return total[7:0];
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Driver: predict on each input transfer, then offer the next item
  always @(posedge clk) begin : drive_input
    mac_item_t nxt;
    if (in_valid && !in_stall) begin
      if (in_first) mac_sum = in_bias;
      mac_sum = mac_sum + (int'(in_activation) + int'(shadow_inoff)) * int'(in_weight);
      if (in_last) predicted_results.push_back(requantize_sum(mac_sum));
    end
    if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (rst_n && queued_items.size() != 0) begin
        nxt = queued_items.pop_front();
        in_first      <= nxt.first;
        in_last       <= nxt.last;
        in_activation <= nxt.activation;
        in_weight     <= nxt.weight;
        in_bias       <= nxt.bias;
        in_valid      <= 1'b1;
        send_gap = send_calm ? 0 : idle_length();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transfer, then pick the next stall
  always @(posedge clk) begin : check_output
    logic signed [7:0] want;
    if (out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        flag_mismatch($sformatf("result %0d with none predicted", out_result));
      end else begin
        want = predicted_results.pop_front();
        if (out_result !== want)
          flag_mismatch($sformatf("result %0d, predicted %0d", out_result, want));
      end
    end
    // One long hold-off so the block backs up into its input
    if (hold_phase && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      recv_gap = recv_calm ? 0 : idle_length();
      out_stall <= (recv_gap != 0);
      if (recv_gap != 0) recv_gap--;
    end
  end

  function automatic void add_item(input bit first, input bit last, input int act,
                                   input int wt, input logic [31:0] bias);
    mac_item_t it;
    it.first = first;
    it.last = last;
    it.activation = 8'(act);
    it.weight = 8'(wt);
    it.bias = bias;
    queued_items.push_back(it);
  endfunction

  // Queue one neuron run, mostly well formed; returns its item count
  function automatic int queue_run();
    int len;
    int kind;
    int restart;
    int r;
    bit has_first;
    bit has_last;
    mac_item_t it;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
    kind = $urandom_range(0, 99);
    has_first = (kind < 85) || (kind >= 90);
    has_last = !(kind >= 90 && kind < 95);
    restart = (kind >= 95 && kind < 97 && len > 2) ? $urandom_range(1, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      if (kind >= 97) begin
        it.first = 1'($urandom_range(0, 1));
        it.last = 1'($urandom_range(0, 1));
      end else begin
        it.first = (i == 0 && has_first) || (i == restart);
        it.last = (i == len - 1) && has_last;
      end
      it.activation = 8'($urandom);
      it.weight = 8'($urandom);
      r = $urandom_range(0, 9);
      if (r < 5) it.bias = int'($urandom_range(0, 8191)) - 4096;
      else if (r < 8) it.bias = int'($urandom_range(0, 2097151)) - 1048576;
      else it.bias = $urandom;
      queued_items.push_back(it);
    end
    return len;
  endfunction

  // Write one register; the unused upper data bits may carry random filler
  task automatic write_reg(input logic [idmr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value,
                           input logic [31:0] keep);
    logic [31:0] filler;
    filler = $urandom_range(0, 1) ? $urandom : 32'd0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (value & keep) | (filler & ~keep);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      idmr_pkg::CFG_QMULT:  shadow_qmult = value[30:0];
      idmr_pkg::CFG_QSHIFT: shadow_qshift = value[5:0];
      idmr_pkg::CFG_INOFF:  shadow_inoff = value[8:0];
      idmr_pkg::CFG_OUTZP:  shadow_zp = value[7:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] qmult, input logic [31:0] qshift,
                              input logic [31:0] inoff, input logic [31:0] outzp);
    write_reg(idmr_pkg::CFG_QMULT, qmult, 32'h7FFF_FFFF);
    write_reg(idmr_pkg::CFG_QSHIFT, qshift, 32'h0000_003F);
    write_reg(idmr_pkg::CFG_INOFF, inoff, 32'h0000_01FF);
    write_reg(idmr_pkg::CFG_OUTZP, outzp, 32'h0000_00FF);
    cfg_valid <= 1'b0;
  endtask

  // Wait for the queue to empty and every predicted result to arrive,
  // sampling between edges so the driver's updates have settled, then
  // give a trailing accumulate time to settle
  task automatic drain();
    do @(negedge clk);
    while (queued_items.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin : stimulus
    int queued;
    int qs;
    int off;
    logic [31:0] qm;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: accumulate from the cleared sum, extremes, wrap
    add_item(0, 1, 0, 0, 32'd0);
    add_item(1, 1, 127, 127, 32'd0);
    add_item(1, 0, -128, -128, 32'h7FFF_FFFF);
    add_item(0, 1, 127, -128, 32'h8000_0000);
    add_item(1, 1, -128, 127, 32'h8000_0000);
    drain();

    // Largest multiplier, left shift by 7, zero point at its top
    program_regs(32'h7FFF_FFFF, 7, -128, 127);
    add_item(1, 1, 127, 127, 32'd1);
    add_item(1, 1, -1, -1, 32'hFFFF_FFFF);
    drain();

    // Zero multiplier, deepest right shift in range
    program_regs(32'd0, -31, 128, -128);
    add_item(1, 1, -128, -128, 32'h1234_5678);
    drain();

    // Shift pattern beyond range to the left, offset beyond range
    program_regs(32'd1, 31, 255, 0);
    add_item(1, 1, 127, -128, 32'd0);
    add_item(1, 1, 0, 1, 32'h7FFF_0000);
    drain();

    // Right shift by 32, most negative offset pattern
    program_regs(32'h7FFF_FFFF, -32, -256, 5);
    add_item(1, 1, -128, 127, 32'h8000_0000);
    add_item(1, 1, 127, 127, 32'h7FFF_FFFF);
    drain();

    // Ties in the rounding right shift, both signs
    program_regs(32'h7FFF_FFFF, -1, 0, 0);
    add_item(1, 1, 0, 0, 32'd1);
    add_item(1, 1, 0, 0, 32'hFFFF_FFFF);
    add_item(1, 1, 0, 0, 32'd3);
    add_item(1, 1, 0, 0, 32'hFFFF_FFFD);
    drain();

    // Random runs under a series of settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: program_regs(32'h7FFF_FFFF, -31, -128, -128);
        1: program_regs(32'd0, 7, 128, 127);
        default: begin
          qm = ($urandom_range(0, 4) == 0) ? $urandom
                                            : $urandom_range(32'h4000_0000, 32'h7FFF_FFFF);
          qs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                            : -int'($urandom_range(6, 14));
          off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                             : int'($urandom_range(0, 256)) - 128;
          program_regs(qm, qs, off, $urandom_range(0, 255));
        end
      endcase
      send_calm = (ph == 2 || ph == 3);
      recv_calm = (ph == 5);
      if (ph == 3) hold_phase = 1'b1;
      queued = 0;
      while (queued < 132) queued += queue_run();
      drain();
    end

    if (mismatch_count == 0) begin
      $display("int8_dense_mac_requantize_test: PASS");
    end else begin
      $display("int8_dense_mac_requantize_test: FAIL");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin : watchdog
    #2_400_000;
    $display("int8_dense_mac_requantize_test: FAIL");
    $finish;
  end

endmodule
